>>> rtl/acld_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and command text for the ASCII command line decoder.
package acld_pkg;

    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_LF = 8'd10;

    localparam int NUM_PAT = 13;
    localparam logic [6:0] DUTY_LIMIT = 7'd100;

    // command index
    localparam logic [3:0] P_PING       = 4'd0;
    localparam logic [3:0] P_STATE      = 4'd1;
    localparam logic [3:0] P_DIST       = 4'd2;
    localparam logic [3:0] P_RSTART     = 4'd3;
    localparam logic [3:0] P_RCANCEL    = 4'd4;
    localparam logic [3:0] P_GATE       = 4'd5;
    localparam logic [3:0] P_RED_ON     = 4'd6;
    localparam logic [3:0] P_RED_OFF    = 4'd7;
    localparam logic [3:0] P_GREEN_ON   = 4'd8;
    localparam logic [3:0] P_GREEN_OFF  = 4'd9;
    localparam logic [3:0] P_MSTOP      = 4'd10;
    localparam logic [3:0] P_CW         = 4'd11;
    localparam logic [3:0] P_CCW        = 4'd12;

    // response codes
    localparam logic [3:0] R_PONG      = 4'd0;
    localparam logic [3:0] R_STATE     = 4'd1;
    localparam logic [3:0] R_DIST      = 4'd2;
    localparam logic [3:0] R_RECOG     = 4'd3;
    localparam logic [3:0] R_SCAN      = 4'd4;
    localparam logic [3:0] R_GATE      = 4'd5;
    localparam logic [3:0] R_LED       = 4'd6;
    localparam logic [3:0] R_MSTOP     = 4'd7;
    localparam logic [3:0] R_CW        = 4'd8;
    localparam logic [3:0] R_CCW       = 4'd9;
    localparam logic [3:0] R_GATE_BUSY = 4'd10;
    localparam logic [3:0] R_BAD_DUTY  = 4'd11;
    localparam logic [3:0] R_UNKNOWN   = 4'd12;
    localparam logic [3:0] R_TOO_LONG  = 4'd13;

    localparam logic [1:0] SA_NONE     = 2'd0;
    localparam logic [1:0] SA_SCAN_OFF = 2'd1;
    localparam logic [1:0] SA_SCAN_ON  = 2'd2;
    localparam logic [1:0] SA_MOTOR    = 2'd3;

    localparam logic [2:0] LA_NONE      = 3'd0;
    localparam logic [2:0] LA_RED_ON    = 3'd1;
    localparam logic [2:0] LA_RED_OFF   = 3'd2;
    localparam logic [2:0] LA_GREEN_ON  = 3'd3;
    localparam logic [2:0] LA_GREEN_OFF = 3'd4;

    localparam logic [1:0] MA_NONE = 2'd0;
    localparam logic [1:0] MA_STOP = 2'd1;
    localparam logic [1:0] MA_CW   = 2'd2;
    localparam logic [1:0] MA_CCW  = 2'd3;

    typedef struct packed {
        logic       init;
        logic       step;
        logic [7:0] ch;
    } acld_mctl_t;

    typedef struct packed {
        logic [NUM_PAT-1:0] alive;
        logic               duty_bad;
        logic [6:0]         duty;
    } acld_mstat_t;

    function automatic logic [103:0] pat_text(input logic [3:0] k);
        logic [103:0] s;
        case (k)
            P_PING:      s = {"PING", {9{8'h00}}};
            P_STATE:     s = {"STATE?", {7{8'h00}}};
            P_DIST:      s = {"DIST?", {8{8'h00}}};
            P_RSTART:    s = {"RECOG START", {2{8'h00}}};
            P_RCANCEL:   s = {"RECOG CANCEL", 8'h00};
            P_GATE:      s = {"GATE OPEN", {4{8'h00}}};
            P_RED_ON:    s = {"LED RED ON", {3{8'h00}}};
            P_RED_OFF:   s = {"LED RED OFF", {2{8'h00}}};
            P_GREEN_ON:  s = {"LED GREEN ON", 8'h00};
            P_GREEN_OFF: s = "LED GREEN OFF";
            P_MSTOP:     s = {"MOTOR STOP", {3{8'h00}}};
            P_CW:        s = {"MOTOR CW ", {4{8'h00}}};
            P_CCW:       s = {"MOTOR CCW ", {3{8'h00}}};
            default:     s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] pat_char(input logic [3:0] k, input logic [3:0] i);
        logic [103:0] s;
        s = pat_text(k);
        return s[103 - 8*i -: 8];
    endfunction

    function automatic logic [3:0] pat_len(input logic [3:0] k);
        logic [3:0] n;
        case (k)
            P_PING:      n = 4'd4;
            P_STATE:     n = 4'd6;
            P_DIST:      n = 4'd5;
            P_RSTART:    n = 4'd11;
            P_RCANCEL:   n = 4'd12;
            P_GATE:      n = 4'd9;
            P_RED_ON:    n = 4'd10;
            P_RED_OFF:   n = 4'd11;
            P_GREEN_ON:  n = 4'd12;
            P_GREEN_OFF: n = 4'd13;
            P_MSTOP:     n = 4'd10;
            P_CW:        n = 4'd9;
            P_CCW:       n = 4'd10;
            default:     n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

>>> rtl/acld_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module acld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/acld_match.sv
`timescale 1ns / 1ps
// Shared compare unit: one character per step against all commands, plus duty digits.
module acld_match #(
    parameter int IW = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  acld_pkg::acld_mctl_t  ctl,
    input  logic [IW-1:0]      idx,
    output acld_pkg::acld_mstat_t stat
);

    logic [acld_pkg::NUM_PAT-1:0] alive_reg;
    logic [acld_pkg::NUM_PAT-1:0] alive_next;
    logic                         bad_reg;
    logic [6:0]                   duty_reg;
    logic [7:0]                   ch_up;
    logic                         dig_mode;
    logic                         is_dig;
    logic [7:0]                   dig_off;
    logic [10:0]                  duty_calc;

    always_comb
    begin
        ch_up = ctl.ch;
        if (ctl.ch >= "a" && ctl.ch <= "z")
        begin
            ch_up = ctl.ch - 8'd32;
        end
        for (int k = 0; k < acld_pkg::NUM_PAT; k++)
        begin
            if (idx < IW'(acld_pkg::pat_len(4'(k))))
            begin
                alive_next[k] = alive_reg[k] &
                    (acld_pkg::pat_char(4'(k), idx[3:0]) == ch_up);
            end
            else
            begin
                // past the text: prefix commands keep going, exact ones drop
                alive_next[k] = alive_reg[k] &
                    ((4'(k) == acld_pkg::P_CW) || (4'(k) == acld_pkg::P_CCW));
            end
        end
        dig_mode = (alive_reg[acld_pkg::P_CW] && idx >= IW'(9)) ||
                   (alive_reg[acld_pkg::P_CCW] && idx >= IW'(10));
        is_dig    = (ctl.ch >= "0") && (ctl.ch <= "9");
        dig_off   = ctl.ch - "0";
        duty_calc = 11'(duty_reg) * 11'd10 + 11'(dig_off[3:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg <= '0;
            bad_reg   <= 1'b0;
            duty_reg  <= '0;
        end
        else if (ctl.init)
        begin
            alive_reg <= '1;
            bad_reg   <= 1'b0;
            duty_reg  <= '0;
        end
        else if (ctl.step)
        begin
            alive_reg <= alive_next;
            if (dig_mode)
            begin
                if (!is_dig || duty_calc > 11'(acld_pkg::DUTY_LIMIT))
                begin
                    bad_reg <= 1'b1;
                end
                else
                begin
                    duty_reg <= duty_calc[6:0];
                end
            end
        end
    end

    assign stat.alive    = alive_reg;
    assign stat.duty_bad = bad_reg;
    assign stat.duty     = duty_reg;

endmodule

>>> rtl/ascii_command_line_decoder_top.sv
`timescale 1ns / 1ps
// ASCII command line decoder: top level with line store, sequencer and result register.
// Takes one received character per transaction while idle. Ordinary characters
// are written into a line RAM of LINE_CAPACITY-1 entries; a carriage return is
// dropped; a character that finds the line full sets an overflow flag.
// A newline on an overflowed line gives the too-long response at once. Otherwise
// the sequencer walks the stored line through the shared compare unit, one
// character at a time (RAM read, then compare), stopping early at a zero byte,
// then decides the result in a separate state. An empty line gives no result.
// The result sits in an output register; further characters are taken while
// it waits, only a newline is held off until it has been taken. The
// gate_moving, scanning_off, current_state and distance_cm fields are sampled
// with the newline transaction. No clearing pass is needed after reset.
module ascii_command_line_decoder_top #(
    parameter int LINE_CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        gate_moving,
    input  logic        scanning_off,
    input  logic [2:0]  current_state,
    input  logic [15:0] distance_cm,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  response,
    output logic [1:0]  state_action,
    output logic        gate_open_req,
    output logic [2:0]  led_action,
    output logic [1:0]  motor_action,
    output logic [6:0]  duty_pct,
    output logic [2:0]  state_echo,
    output logic [15:0] distance_echo
);

    localparam int DEPTH = LINE_CAPACITY - 1;
    localparam int LW    = $clog2(LINE_CAPACITY);
    localparam int AW    = $clog2(DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_CMP   = 2'd2;
    localparam logic [1:0] S_DEC   = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [LW-1:0] len_reg, len_next;
    logic          ovf_reg, ovf_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic [LW-1:0] n_reg, n_next;
    logic          busy_reg, off_reg;
    logic [2:0]    st_reg;
    logic [15:0]   dist_reg;

    logic          ov_reg, ov_next;
    logic [3:0]    resp_reg, resp_next;
    logic [1:0]    sa_reg, sa_next;
    logic          gs_reg, gs_next;
    logic [2:0]    la_reg, la_next;
    logic [1:0]    ma_reg, ma_next;
    logic [6:0]    md_reg, md_next;
    logic [2:0]    se_reg, se_next;
    logic [15:0]   de_reg, de_next;

    logic          accept;
    logic          is_cr, is_lf, has_room;
    logic          ram_we;
    logic [7:0]    ram_rdata;
    acld_pkg::acld_mctl_t  mctl;
    acld_pkg::acld_mstat_t mstat;
    logic [acld_pkg::NUM_PAT-1:0] exact;
    logic          cw_hit, ccw_hit;

    assign is_cr    = (rx_byte == acld_pkg::CH_CR);
    assign is_lf    = (rx_byte == acld_pkg::CH_LF);
    assign has_room = (len_reg < LW'(DEPTH));
    assign in_stall = (state_reg != S_IDLE) || (ov_reg && is_lf);
    assign accept   = in_valid && !in_stall;
    assign ram_we   = accept && !is_cr && !is_lf && has_room;

    acld_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (len_reg[AW-1:0]),
        .wdata (rx_byte),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign mctl.init = accept && is_lf;
    assign mctl.step = (state_reg == S_CMP) && (ram_rdata != 8'd0);
    assign mctl.ch   = ram_rdata;

    acld_match #(
        .IW (LW)
    ) u_match (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mctl),
        .idx   (idx_reg),
        .stat  (mstat)
    );

    always_comb
    begin
        for (int k = 0; k < acld_pkg::NUM_PAT; k++)
        begin
            exact[k] = mstat.alive[k] && (n_reg == LW'(acld_pkg::pat_len(4'(k))));
        end
        cw_hit  = mstat.alive[acld_pkg::P_CW] && (n_reg >= LW'(9));
        ccw_hit = mstat.alive[acld_pkg::P_CCW] && (n_reg >= LW'(10));
    end

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        ov_next    = ov_reg;
        resp_next  = resp_reg;
        sa_next    = sa_reg;
        gs_next    = gs_reg;
        la_next    = la_reg;
        ma_next    = ma_reg;
        md_next    = md_reg;
        se_next    = se_reg;
        de_next    = de_reg;

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && !is_cr)
                begin
                    if (!is_lf)
                    begin
                        if (has_room)
                        begin
                            len_next = len_reg + LW'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else
                    begin
                        len_next = '0;
                        ovf_next = 1'b0;
                        if (ovf_reg)
                        begin
                            ov_next   = 1'b1;
                            resp_next = acld_pkg::R_TOO_LONG;
                            sa_next   = acld_pkg::SA_NONE;
                            gs_next   = 1'b0;
                            la_next   = acld_pkg::LA_NONE;
                            ma_next   = acld_pkg::MA_NONE;
                            md_next   = '0;
                            se_next   = '0;
                            de_next   = '0;
                        end
                        else if (len_reg != '0)
                        begin
                            cnt_next   = len_reg;
                            idx_next   = '0;
                            state_next = S_FETCH;
                        end
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (ram_rdata == 8'd0)
                begin
                    n_next     = idx_reg;
                    state_next = S_DEC;
                end
                else if (idx_reg + LW'(1) == cnt_reg)
                begin
                    n_next     = cnt_reg;
                    state_next = S_DEC;
                end
                else
                begin
                    idx_next   = idx_reg + LW'(1);
                    state_next = S_FETCH;
                end
            end
            S_DEC:
            begin
                state_next = S_IDLE;
                if (n_reg != '0)
                begin
                    ov_next   = 1'b1;
                    resp_next = acld_pkg::R_UNKNOWN;
                    sa_next   = acld_pkg::SA_NONE;
                    gs_next   = 1'b0;
                    la_next   = acld_pkg::LA_NONE;
                    ma_next   = acld_pkg::MA_NONE;
                    md_next   = '0;
                    se_next   = '0;
                    de_next   = '0;
                    if (exact[acld_pkg::P_PING])
                    begin
                        resp_next = acld_pkg::R_PONG;
                    end
                    else if (exact[acld_pkg::P_STATE])
                    begin
                        resp_next = acld_pkg::R_STATE;
                        se_next   = st_reg;
                    end
                    else if (exact[acld_pkg::P_DIST])
                    begin
                        resp_next = acld_pkg::R_DIST;
                        de_next   = dist_reg;
                    end
                    else if (exact[acld_pkg::P_RSTART])
                    begin
                        resp_next = acld_pkg::R_RECOG;
                        sa_next   = acld_pkg::SA_SCAN_OFF;
                    end
                    else if (exact[acld_pkg::P_RCANCEL])
                    begin
                        resp_next = acld_pkg::R_SCAN;
                        sa_next   = off_reg ? acld_pkg::SA_SCAN_ON : acld_pkg::SA_NONE;
                    end
                    else if (exact[acld_pkg::P_GATE])
                    begin
                        if (busy_reg)
                        begin
                            resp_next = acld_pkg::R_GATE_BUSY;
                        end
                        else
                        begin
                            resp_next = acld_pkg::R_GATE;
                            sa_next   = acld_pkg::SA_MOTOR;
                            gs_next   = 1'b1;
                        end
                    end
                    else if (exact[acld_pkg::P_RED_ON])
                    begin
                        resp_next = acld_pkg::R_LED;
                        la_next   = acld_pkg::LA_RED_ON;
                    end
                    else if (exact[acld_pkg::P_RED_OFF])
                    begin
                        resp_next = acld_pkg::R_LED;
                        la_next   = acld_pkg::LA_RED_OFF;
                    end
                    else if (exact[acld_pkg::P_GREEN_ON])
                    begin
                        resp_next = acld_pkg::R_LED;
                        la_next   = acld_pkg::LA_GREEN_ON;
                    end
                    else if (exact[acld_pkg::P_GREEN_OFF])
                    begin
                        resp_next = acld_pkg::R_LED;
                        la_next   = acld_pkg::LA_GREEN_OFF;
                    end
                    else if (exact[acld_pkg::P_MSTOP])
                    begin
                        resp_next = acld_pkg::R_MSTOP;
                        ma_next   = acld_pkg::MA_STOP;
                    end
                    else if (cw_hit)
                    begin
                        // need at least one digit after the space
                        if (!mstat.duty_bad && n_reg > LW'(9))
                        begin
                            resp_next = acld_pkg::R_CW;
                            ma_next   = acld_pkg::MA_CW;
                            md_next   = mstat.duty;
                        end
                        else
                        begin
                            resp_next = acld_pkg::R_BAD_DUTY;
                        end
                    end
                    else if (ccw_hit)
                    begin
                        if (!mstat.duty_bad && n_reg > LW'(10))
                        begin
                            resp_next = acld_pkg::R_CCW;
                            ma_next   = acld_pkg::MA_CCW;
                            md_next   = mstat.duty;
                        end
                        else
                        begin
                            resp_next = acld_pkg::R_BAD_DUTY;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            n_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
            ov_reg    <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept && is_lf)
        begin
            busy_reg <= gate_moving;
            off_reg  <= scanning_off;
            st_reg   <= current_state;
            dist_reg <= distance_cm;
        end
        resp_reg <= resp_next;
        sa_reg   <= sa_next;
        gs_reg   <= gs_next;
        la_reg   <= la_next;
        ma_reg   <= ma_next;
        md_reg   <= md_next;
        se_reg   <= se_next;
        de_reg   <= de_next;
    end

    assign out_valid     = ov_reg;
    assign response      = resp_reg;
    assign state_action  = sa_reg;
    assign gate_open_req = gs_reg;
    assign led_action    = la_reg;
    assign motor_action  = ma_reg;
    assign duty_pct      = md_reg;
    assign state_echo    = se_reg;
    assign distance_echo = de_reg;

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input taken while scanning a line");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(DEPTH))
        else $error("line length beyond store depth");

    a_scan_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (idx_reg < cnt_reg))
        else $error("scan index past latched line length");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |=> (ov_reg && $stable(resp_reg)))
        else $error("stalled result lost or changed");

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Testbench for the ASCII command line decoder: random and directed command lines.
module tb;

    // One received character with the status fields sampled alongside it.
    typedef struct packed {
        logic [7:0]  ch;
        logic        busy;
        logic        off;
        logic [2:0]  st;
        logic [15:0] dist_cm;
    } rx_txn_t;

    // One decoded command result.
    typedef struct packed {
        logic [3:0]  resp;
        logic [1:0]  sa;
        logic        gs;
        logic [2:0]  la;
        logic [1:0]  ma;
        logic [6:0]  duty;
        logic [2:0]  se;
        logic [15:0] de;
    } cmd_result_t;

    localparam int LINE_MAX = 63;
    localparam int STALL_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        gate_moving;
    logic        scanning_off;
    logic [2:0]  current_state;
    logic [15:0] distance_cm;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  response;
    logic [1:0]  state_action;
    logic        gate_open_req;
    logic [2:0]  led_action;
    logic [1:0]  motor_action;
    logic [6:0]  duty_pct;
    logic [2:0]  state_echo;
    logic [15:0] distance_echo;

    ascii_command_line_decoder_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .rx_byte(rx_byte), .gate_moving(gate_moving), .scanning_off(scanning_off),
        .current_state(current_state), .distance_cm(distance_cm),
        .out_valid(out_valid), .out_stall(out_stall),
        .response(response), .state_action(state_action),
        .gate_open_req(gate_open_req),
        .led_action(led_action), .motor_action(motor_action), .duty_pct(duty_pct),
        .state_echo(state_echo), .distance_echo(distance_echo)
    );

    rx_txn_t     pending_rx[$];
    cmd_result_t expected_results[$];
    int          mismatch_count;
    int          idle_cycles;
    bit          quiet_phase;   // no idling on either side while set
    bit          in_taken;      // input transaction accepted at the last rising edge

    // Predictor copy of the line store.
    logic [7:0]  line_buf[LINE_MAX];
    int          line_len;
    bit          line_ovf;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    function automatic bit line_is(input logic [7:0] l[LINE_MAX], input int n, input string w);
        if (n != w.len())
            return 1'b0;
        for (int i = 0; i < n; i++)
            if (l[i] != w[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit line_starts(input logic [7:0] l[LINE_MAX], input int n,
                                       input string w);
        if (n < w.len())
            return 1'b0;
        for (int i = 0; i < w.len(); i++)
            if (l[i] != w[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // Parse the duty digits from position 'from'; returns -1 when malformed.
    function automatic int parse_duty(input logic [7:0] l[LINE_MAX], input int from,
                                      input int n);
        int v;
        v = 0;
        if (from >= n)
            return -1;
        for (int i = from; i < n; i++)
        begin
            if (l[i] < "0" || l[i] > "9")
                return -1;
            v = v * 10 + (l[i] - "0");
            if (v > 100)
                return -1;
        end
        return v;
    endfunction

    // Advance the line model by one accepted character and queue any result.
    task automatic decode_rx(input rx_txn_t t);
        logic [7:0]  u[LINE_MAX];
        int          n;
        int          d;
        cmd_result_t r;
        n = 0;
        r = '0;
        if (t.ch == acld_pkg::CH_CR)
            return;
        if (t.ch != acld_pkg::CH_LF)
        begin
            if (line_len < LINE_MAX)
            begin
                line_buf[line_len] = t.ch;
                line_len++;
            end
            else
                line_ovf = 1'b1;
            return;
        end
        if (line_ovf)
        begin
            line_len = 0;
            line_ovf = 1'b0;
            r.resp = acld_pkg::R_TOO_LONG;
            expected_results.push_back(r);
            return;
        end
        while (n < line_len && line_buf[n] != 8'h00)
        begin
            u[n] = (line_buf[n] >= "a" && line_buf[n] <= "z") ? line_buf[n] - 8'd32
                                                               : line_buf[n];
            n++;
        end
        line_len = 0;
        if (n == 0)
            return;
        if (line_is(u, n, "PING"))
            r.resp = acld_pkg::R_PONG;
        else if (line_is(u, n, "STATE?"))
        begin
            r.resp = acld_pkg::R_STATE;
            r.se = t.st;
        end
        else if (line_is(u, n, "DIST?"))
        begin
            r.resp = acld_pkg::R_DIST;
            r.de = t.dist_cm;
        end
        else if (line_is(u, n, "RECOG START"))
        begin
            r.resp = acld_pkg::R_RECOG;
            r.sa = acld_pkg::SA_SCAN_OFF;
        end
        else if (line_is(u, n, "RECOG CANCEL"))
        begin
            r.resp = acld_pkg::R_SCAN;
            r.sa = t.off ? acld_pkg::SA_SCAN_ON : acld_pkg::SA_NONE;
        end
        else if (line_is(u, n, "GATE OPEN"))
        begin
            if (t.busy)
                r.resp = acld_pkg::R_GATE_BUSY;
            else
            begin
                r.resp = acld_pkg::R_GATE;
                r.sa = acld_pkg::SA_MOTOR;
                r.gs = 1'b1;
            end
        end
        else if (line_is(u, n, "LED RED ON"))
        begin
            r.resp = acld_pkg::R_LED;
            r.la = acld_pkg::LA_RED_ON;
        end
        else if (line_is(u, n, "LED RED OFF"))
        begin
            r.resp = acld_pkg::R_LED;
            r.la = acld_pkg::LA_RED_OFF;
        end
        else if (line_is(u, n, "LED GREEN ON"))
        begin
            r.resp = acld_pkg::R_LED;
            r.la = acld_pkg::LA_GREEN_ON;
        end
        else if (line_is(u, n, "LED GREEN OFF"))
        begin
            r.resp = acld_pkg::R_LED;
            r.la = acld_pkg::LA_GREEN_OFF;
        end
        else if (line_is(u, n, "MOTOR STOP"))
        begin
            r.resp = acld_pkg::R_MSTOP;
            r.ma = acld_pkg::MA_STOP;
        end
        else if (line_starts(u, n, "MOTOR CW "))
        begin
            d = parse_duty(u, 9, n);
            if (d < 0)
                r.resp = acld_pkg::R_BAD_DUTY;
            else
            begin
                r.resp = acld_pkg::R_CW;
                r.ma = acld_pkg::MA_CW;
                r.duty = 7'(d);
            end
        end
        else if (line_starts(u, n, "MOTOR CCW "))
        begin
            d = parse_duty(u, 10, n);
            if (d < 0)
                r.resp = acld_pkg::R_BAD_DUTY;
            else
            begin
                r.resp = acld_pkg::R_CCW;
                r.ma = acld_pkg::MA_CCW;
                r.duty = 7'(d);
            end
        end
        else
            r.resp = acld_pkg::R_UNKNOWN;
        expected_results.push_back(r);
    endtask

    // Queue one character with random status fields.
    task automatic push_ch(input logic [7:0] c);
        rx_txn_t t;
        t.ch = c;
        t.busy = 1'($urandom_range(0, 1));
        t.off = 1'($urandom_range(0, 1));
        t.st = 3'($urandom_range(0, 7));
        t.dist_cm = 16'($urandom);
        pending_rx.push_back(t);
    endtask

    // Queue a whole line, optionally with random case and a stray carriage return.
    task automatic push_line(input string s, input bit mangle);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++)
        begin
            c = s[i];
            if (mangle && c >= "A" && c <= "Z" && $urandom_range(0, 1))
                c = c + 8'd32;
            push_ch(c);
            if (mangle && $urandom_range(0, 15) == 0)
                push_ch(acld_pkg::CH_CR);
        end
        push_ch(acld_pkg::CH_LF);
    endtask

    function automatic string rand_duty();
        case ($urandom_range(0, 5))
            0: return "";
            1: return $sformatf("%0d", $urandom_range(101, 999));
            2: return $sformatf("00%0d", $urandom_range(0, 100));
            3: return "5x";
            default: return $sformatf("%0d", $urandom_range(0, 100));
        endcase
    endfunction

    function automatic string rand_command();
        case ($urandom_range(0, 15))
            0: return "PING";
            1: return "STATE?";
            2: return "DIST?";
            3: return "RECOG START";
            4: return "RECOG CANCEL";
            5: return "GATE OPEN";
            6: return "LED RED ON";
            7: return "LED RED OFF";
            8: return "LED GREEN ON";
            9: return "LED GREEN OFF";
            10: return "MOTOR STOP";
            11: return {"MOTOR CW ", rand_duty()};
            12: return {"MOTOR CCW ", rand_duty()};
            13: return "PIN";
            14: return "MOTOR STOPX";
            default: return "";
        endcase
    endfunction

    // Driver: changes inputs on the falling edge; holds a transaction until accepted.
    always @(negedge clk)
    begin
        if (rst_n && (in_taken || !in_valid))
        begin
            if (in_taken)
                void'(pending_rx.pop_front());
            if (pending_rx.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= 12))
            begin
                in_valid <= 1'b1;
                rx_byte <= pending_rx[0].ch;
                gate_moving <= pending_rx[0].busy;
                scanning_off <= pending_rx[0].off;
                current_state <= pending_rx[0].st;
                distance_cm <= pending_rx[0].dist_cm;
            end
            else
                in_valid <= 1'b0;
        end
        if (rst_n)
            out_stall <= quiet_phase ? 1'b0 : ($urandom_range(0, 99) < 12);
    end

    // Monitor: predicts on accepted inputs and checks accepted results.
    always @(posedge clk)
    begin
        cmd_result_t want;
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            idle_cycles <= idle_cycles + 1;
            if (out_valid && !out_stall)
            begin
                idle_cycles <= 0;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result, response", response, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (response != want.resp)
                        report_mismatch("response", response, want.resp);
                    if (state_action != want.sa)
                        report_mismatch("state_action", state_action, want.sa);
                    if (gate_open_req != want.gs)
                        report_mismatch("gate_open_req", gate_open_req, want.gs);
                    if (led_action != want.la)
                        report_mismatch("led_action", led_action, want.la);
                    if (motor_action != want.ma)
                        report_mismatch("motor_action", motor_action, want.ma);
                    if (duty_pct != want.duty)
                        report_mismatch("duty_pct", duty_pct, want.duty);
                    if (state_echo != want.se)
                        report_mismatch("state_echo", state_echo, want.se);
                    if (distance_echo != want.de)
                        report_mismatch("distance_echo", distance_echo, want.de);
                end
            end
            if (in_valid && !in_stall)
            begin
                idle_cycles <= 0;
                decode_rx('{rx_byte, gate_moving, scanning_off, current_state, distance_cm});
            end
        end
    end

    // Watchdog: fails the run once idle_cycles reaches STALL_LIMIT.
    always @(posedge clk)
    begin
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("ascii_command_line_decoder_top verification failed");
            $finish;
        end
    end

    initial
    begin
        string s;
        mismatch_count = 0;
        idle_cycles = 0;
        quiet_phase = 1'b0;
        in_taken = 1'b0;
        line_len = 0;
        line_ovf = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        rx_byte = '0;
        gate_moving = 1'b0;
        scanning_off = 1'b0;
        current_state = '0;
        distance_cm = '0;

        // Directed: every command, case folding, duty edges, empty and zero-led lines,
        // a full 63-char line, and an overflowed line.
        push_line("PING", 1'b0);
        push_line("state?", 1'b0);
        push_line("Dist?", 1'b0);
        push_line("RECOG START", 1'b0);
        push_line("RECOG CANCEL", 1'b0);
        push_line("GATE OPEN", 1'b0);
        push_line("LED RED ON", 1'b0);
        push_line("LED RED OFF", 1'b0);
        push_line("LED GREEN ON", 1'b0);
        push_line("LED GREEN OFF", 1'b0);
        push_line("MOTOR STOP", 1'b0);
        push_line("MOTOR CW 100", 1'b0);
        push_line("MOTOR CCW 0", 1'b0);
        push_line("MOTOR CW 101", 1'b0);
        push_line("MOTOR CCW ", 1'b0);
        push_line("", 1'b0);
        push_ch(8'h00);
        push_line("PING", 1'b0);
        push_line("PING", 1'b0);
        pending_rx[pending_rx.size() - 1].ch = 8'h00;   // PING then zero byte, no newline yet
        push_ch(8'hFF);
        push_ch(acld_pkg::CH_LF);
        s = "";
        for (int i = 0; i < LINE_MAX; i++)
            s = {s, "A"};
        push_line(s, 1'b0);
        push_line({s, "Z"}, 1'b0);

        // Random: mostly valid commands with random case, some noise bytes and long lines.
        while (pending_rx.size() < 1800)
        begin
            case ($urandom_range(0, 19))
                0: begin
                    for (int i = $urandom_range(1, 6); i > 0; i--)
                        push_ch(8'($urandom_range(0, 255)));
                end
                1: begin
                    s = "";
                    for (int i = $urandom_range(55, 70); i > 0; i--)
                        s = {s, "x"};
                    push_line(s, 1'b1);
                end
                default: push_line(rand_command(), 1'b1);
            endcase
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Quiet stretch for a while in the middle of the run.
        wait (pending_rx.size() < 1200);
        quiet_phase = 1'b1;
        wait (pending_rx.size() < 800);
        quiet_phase = 1'b0;

        wait (pending_rx.size() == 0 && !in_valid);
        wait (expected_results.size() == 0);
        repeat (200) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("ascii_command_line_decoder_top verification clean");
        else
            $display("ascii_command_line_decoder_top verification failed");
        $finish;
    end
endmodule

>>> sim.f
rtl/acld_pkg.sv
rtl/acld_ram.sv
rtl/acld_match.sv
rtl/ascii_command_line_decoder_top.sv
bench/tb.sv
